@@ hdl/mclr_pkg.sv @@
// Package: shared types and constants for the median-cut light region block.
`timescale 1ns / 1ps
package mclr_pkg;

  localparam int unsigned TableW = 32;

  // Configuration register indexes
  localparam logic [1:0] CfgImageWidth  = 2'd0;
  localparam logic [1:0] CfgImageHeight = 2'd1;
  localparam logic [1:0] CfgCutLevels   = 2'd2;

  typedef enum logic [13:0] {
    StLoad   = 14'b00000000000001,
    StRoot   = 14'b00000000000010,
    StPop    = 14'b00000000000100,
    StSetup  = 14'b00000000001000,
    StProbe  = 14'b00000000010000,
    StRd0    = 14'b00000000100000,
    StRd1    = 14'b00000001000000,
    StRd2    = 14'b00000010000000,
    StRd3    = 14'b00000100000000,
    StAcc    = 14'b00001000000000,
    StStep   = 14'b00010000000000,
    StSplit  = 14'b00100000000000,
    StEmit   = 14'b01000000000000,
    StNext   = 14'b10000000000000
  } state_e;

  // What the current area sum is for
  typedef enum logic [2:0] {
    SumRoot   = 3'b001,
    SumSearch = 3'b010,
    SumFirst  = 3'b100
  } sum_e;

endpackage

@@ hdl/median_cut_light_regions.sv @@
// Top level: median-cut light region finder over a loaded summed-area table.
`timescale 1ns / 1ps
// Loading takes one table entry per cycle straight into the table memory; the
// final entry starts the cutting, during which no entry is taken. Every area
// sum is four reads of the single-port table memory plus an accumulate step;
// one half-energy search step adds a probe and a compare step, and a search
// takes one step per halving of the extent (at most 10 with the default
// limits). A split node costs one search and one sum, a leaf two searches;
// a stall on the output holds the run. Once the last region sits in the output
// register, table entries are taken again. A stored summed-area table needs
// no clearing.
module median_cut_light_regions #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_LEVELS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] table_value_i,
  input  logic        last_entry_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  region_x_start_o,
  output logic [10:0] region_x_end_o,
  output logic [8:0]  region_y_start_o,
  output logic [9:0]  region_y_end_o,
  output logic [9:0]  centroid_col_o,
  output logic [8:0]  centroid_row_o,
  output logic [31:0] region_energy_o,
  output logic        last_region_o
);
  import mclr_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW    = XW + 1;     // signed coordinate width
  localparam int unsigned RW    = YW + 1;
  localparam int unsigned SD    = MAX_LEVELS + 1;
  localparam int unsigned SPW   = $clog2(SD + 1);
  localparam int unsigned SIW   = $clog2(SD);
  localparam int unsigned NW    = (XW > YW) ? XW : YW;
  localparam int unsigned LW    = 3;

  // ---------------- configuration ----------------
  logic [10:0] img_w_q;
  logic [9:0]  img_h_q;
  logic [2:0]  lvl_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 11'd1024;
      img_h_q <= 10'd512;
      lvl_q   <= 3'd6;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageWidth:  img_w_q <= cfg_data_i;
        CfgImageHeight: img_h_q <= cfg_data_i[9:0];
        CfgCutLevels:   lvl_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [XW-1:0] eff_w_q;
  logic [YW-1:0] eff_h_q;
  logic [LW-1:0] eff_l_q;

  // ---------------- table memory ----------------
  logic [TableW-1:0] mem [Depth];
  logic [TableW-1:0] rd_q;
  logic              we;
  logic [AW-1:0]     waddr_q;
  logic [AW-1:0]     raddr;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr_q] <= table_value_i;
    rd_q <= mem[raddr];
  end

  // ---------------- stack ----------------
  logic [XW-1:0]     sx  [SD];
  logic [YW-1:0]     sy  [SD];
  logic [XW-1:0]     sw  [SD];
  logic [YW-1:0]     sh  [SD];
  logic [TableW-1:0] se  [SD];
  logic [LW-1:0]     sl  [SD];
  logic [SPW-1:0]    sp_q;

  // current region
  logic [XW-1:0]     gx_q, gw_q;
  logic [YW-1:0]     gy_q, gh_q;
  logic [TableW-1:0] ge_q;
  logic [LW-1:0]     gl_q;

  state_e        st_q;
  sum_e          sum_q;
  logic          axis_q;      // 1: across width
  logic          leaf_q;
  logic          pass_q;      // leaf: 0 = x search, 1 = y search
  logic [NW:0]   lo_q, hi_q, mid_q;
  logic [XW-1:0] kx_q;
  logic [TableW-1:0] acc_q;
  logic [2:0]    rdi_q;

  // rectangle being summed
  logic [XW-1:0] ax_q, aw_q;
  logic [YW-1:0] ay_q, ah_q;

  // output register
  logic          ovalid_q;
  logic [9:0]    o_xs_q, o_cc_q;
  logic [10:0]   o_xe_q;
  logic [8:0]    o_ys_q, o_cr_q;
  logic [9:0]    o_ye_q;
  logic [31:0]   o_e_q;
  logic          o_last_q;

  assign out_valid_o      = ovalid_q;
  assign region_x_start_o = o_xs_q;
  assign region_x_end_o   = o_xe_q;
  assign region_y_start_o = o_ys_q;
  assign region_y_end_o   = o_ye_q;
  assign centroid_col_o   = o_cc_q;
  assign centroid_row_o   = o_cr_q;
  assign region_energy_o  = o_e_q;
  assign last_region_o    = o_last_q;

  assign in_ready_o = (st_q == StLoad);
  assign we = in_valid_i && in_ready_o;

  // corner of read i: 0 (x1,y1) +, 1 (x-1,y1) -, 2 (x1,y-1) -, 3 (x-1,y-1) +
  logic signed [CW:0] cc;
  logic signed [RW:0] cr;
  logic               cin;
  logic [AW+CW:0]     lin;
  always_comb begin
    cc = (rdi_q[0]) ? $signed({2'b00, ax_q}) - 2'sd1
                    : $signed({2'b00, ax_q}) + $signed({2'b00, aw_q}) - 2'sd1;
    cr = (rdi_q[1]) ? $signed({2'b00, ay_q}) - 2'sd1
                    : $signed({2'b00, ay_q}) + $signed({2'b00, ah_q}) - 2'sd1;
    cin = (cc >= 0) && (cr >= 0) && (cc < $signed({2'b00, eff_w_q}))
          && (cr < $signed({2'b00, eff_h_q}));
    lin = (AW+CW+1)'(cr[RW-1:0]) * (AW+CW+1)'(eff_w_q) + (AW+CW+1)'(cc[CW-1:0]);
    raddr = (st_q == StLoad) ? waddr_q : lin[AW-1:0];
  end
  logic cin_q;
  logic [1:0] ri_q;

  // search bookkeeping
  logic [NW:0] n_ext;
  assign n_ext = axis_q ? (NW+1)'(gw_q) : (NW+1)'(gh_q);

  logic [TableW:0] twice;
  assign twice = {acc_q, 1'b0};

  // leaf centroid helpers
  logic [XW:0] pcx;
  logic [YW:0] pcy;
  always_comb begin
    pcx = (kx_q != '0) ? (XW+1)'(gx_q) + (XW+1)'(kx_q) - 1'b1 : (XW+1)'(gx_q);
    if (pcx > (XW+1)'(eff_w_q) - 1'b1) pcx = (XW+1)'(eff_w_q) - 1'b1;
    pcy = (hi_q != '0) ? (YW+1)'(gy_q) + (YW+1)'(hi_q) - 1'b1 : (YW+1)'(gy_q);
    if (pcy > (YW+1)'(eff_h_q) - 1'b1) pcy = (YW+1)'(eff_h_q) - 1'b1;
  end

  logic [SIW-1:0] top;
  assign top = SIW'(sp_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StLoad;
      waddr_q  <= '0;
      sp_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i && st_q != StEmit) ovalid_q <= 1'b0;
      case (st_q)
        StLoad: if (we) begin
          if (last_entry_i) begin
            waddr_q <= '0;
            eff_w_q <= (img_w_q == 0) ? XW'(1) :
                       (32'(img_w_q) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(img_w_q);
            eff_h_q <= (img_h_q == 0) ? YW'(1) :
                       (32'(img_h_q) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(img_h_q);
            eff_l_q <= (32'(lvl_q) > MAX_LEVELS) ? LW'(MAX_LEVELS) : lvl_q;
            st_q    <= StRoot;
          end else begin
            waddr_q <= (waddr_q == AW'(Depth - 1)) ? '0 : waddr_q + 1'b1;
          end
        end
        StRoot: begin
          gx_q <= '0; gy_q <= '0; gw_q <= eff_w_q; gh_q <= eff_h_q; gl_q <= eff_l_q;
          ax_q <= '0; ay_q <= '0; aw_q <= eff_w_q; ah_q <= eff_h_q;
          sum_q <= SumRoot;
          sp_q  <= '0;
          acc_q <= '0; rdi_q <= '0;
          st_q  <= StRd0;
        end
        StPop: begin
          gx_q <= sx[top]; gy_q <= sy[top]; gw_q <= sw[top]; gh_q <= sh[top];
          ge_q <= se[top]; gl_q <= sl[top];
          sp_q <= sp_q - 1'b1;
          pass_q <= 1'b0;
          st_q <= StSetup;
        end
        StSetup: begin
          leaf_q <= (gw_q < 2) || (gh_q < 2) || (gl_q == 0);
          if ((gw_q < 2) || (gh_q < 2) || (gl_q == 0)) axis_q <= !pass_q;
          else axis_q <= (gw_q > gh_q);
          lo_q <= '0;
          st_q <= StNext;
        end
        StNext: begin
          hi_q  <= n_ext;
          mid_q <= n_ext >> 1;
          st_q  <= StProbe;
        end
        StProbe: begin
          if (hi_q - 1'b1 > lo_q && hi_q != 0) begin
            ax_q <= gx_q; ay_q <= gy_q;
            aw_q <= axis_q ? XW'(mid_q) : gw_q;
            ah_q <= axis_q ? gh_q : YW'(mid_q);
            sum_q <= SumSearch;
            acc_q <= '0; rdi_q <= '0;
            st_q <= StRd0;
          end else begin
            st_q <= StSplit;
          end
        end
        StRd0, StRd1, StRd2, StRd3: begin
          // issue read rdi, gather previous
          cin_q <= cin;
          ri_q  <= rdi_q[1:0];
          if (st_q != StRd0) begin
            if (cin_q) acc_q <= (ri_q == 2'd1 || ri_q == 2'd2) ? acc_q - rd_q : acc_q + rd_q;
          end
          rdi_q <= rdi_q + 1'b1;
          case (st_q)
            StRd0:   st_q <= StRd1;
            StRd1:   st_q <= StRd2;
            StRd2:   st_q <= StRd3;
            default: st_q <= StAcc;
          endcase
        end
        StAcc: begin
          if (aw_q == 0 || ah_q == 0) acc_q <= '0;
          else if (cin_q) acc_q <= (ri_q == 2'd1 || ri_q == 2'd2) ? acc_q - rd_q : acc_q + rd_q;
          st_q <= StStep;
        end
        StStep: begin
          case (sum_q)
            SumRoot: begin
              sx[0] <= '0; sy[0] <= '0; sw[0] <= eff_w_q; sh[0] <= eff_h_q;
              se[0] <= acc_q; sl[0] <= eff_l_q;
              sp_q  <= SPW'(1);
              st_q  <= StPop;
            end
            SumSearch: begin
              if (twice < {1'b0, ge_q}) begin
                lo_q  <= mid_q;
                mid_q <= (mid_q + hi_q + 1'b1) >> 1;
              end else begin
                hi_q  <= mid_q;
                mid_q <= (lo_q + mid_q + 1'b1) >> 1;
              end
              st_q <= StProbe;
            end
            default: begin
              // first part sum known: push second then first
              if (axis_q) begin
                sx[SIW'(sp_q)] <= gx_q + XW'(hi_q); sy[SIW'(sp_q)] <= gy_q;
                sw[SIW'(sp_q)] <= gw_q - XW'(hi_q); sh[SIW'(sp_q)] <= gh_q;
                sx[SIW'(sp_q + 1'b1)] <= gx_q; sy[SIW'(sp_q + 1'b1)] <= gy_q;
                sw[SIW'(sp_q + 1'b1)] <= XW'(hi_q); sh[SIW'(sp_q + 1'b1)] <= gh_q;
              end else begin
                sx[SIW'(sp_q)] <= gx_q; sy[SIW'(sp_q)] <= gy_q + YW'(hi_q);
                sw[SIW'(sp_q)] <= gw_q; sh[SIW'(sp_q)] <= gh_q - YW'(hi_q);
                sx[SIW'(sp_q + 1'b1)] <= gx_q; sy[SIW'(sp_q + 1'b1)] <= gy_q;
                sw[SIW'(sp_q + 1'b1)] <= gw_q; sh[SIW'(sp_q + 1'b1)] <= YW'(hi_q);
              end
              se[SIW'(sp_q)] <= ge_q - acc_q; sl[SIW'(sp_q)] <= gl_q - 1'b1;
              se[SIW'(sp_q + 1'b1)] <= acc_q; sl[SIW'(sp_q + 1'b1)] <= gl_q - 1'b1;
              sp_q <= sp_q + SPW'(2);
              st_q <= StPop;
            end
          endcase
        end
        StSplit: begin
          if (leaf_q) begin
            if (!pass_q) begin
              kx_q   <= XW'(hi_q);
              pass_q <= 1'b1;
              axis_q <= 1'b0;
              lo_q   <= '0;
              st_q   <= StNext;
            end else begin
              st_q <= StEmit;
            end
          end else begin
            ax_q <= gx_q; ay_q <= gy_q;
            aw_q <= axis_q ? XW'(hi_q) : gw_q;
            ah_q <= axis_q ? gh_q : YW'(hi_q);
            sum_q <= SumFirst;
            acc_q <= '0; rdi_q <= '0;
            st_q <= StRd0;
          end
        end
        StEmit: if (!ovalid_q || out_ready_i) begin
          ovalid_q <= 1'b1;
          o_xs_q   <= 10'(gx_q);
          o_xe_q   <= 11'((XW+1)'(gx_q) + (XW+1)'(gw_q));
          o_ys_q   <= 9'(gy_q);
          o_ye_q   <= 10'((YW+1)'(gy_q) + (YW+1)'(gh_q));
          o_cc_q   <= 10'(pcx);
          o_cr_q   <= 9'(pcy);
          o_e_q    <= ge_q;
          o_last_q <= (sp_q == 0);
          st_q     <= (sp_q == 0) ? StLoad : StPop;
        end
        default: st_q <= StLoad;
      endcase
    end
  end

endmodule
